// ===== hw/rtl/lifo_stack_with_search_assert.svh =====
// Assertion macros used by the stack top level.
`ifndef LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lifo_stack_with_search: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lifo_stack_with_search: next-cycle check failed");

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Types and codes shared by the LIFO stack modules.
`default_nettype none

package lss_pkg;

    // Request codes; code 7 is unused
    typedef enum logic [2:0] {
        REQ_PUSH     = 3'd0,
        REQ_POP      = 3'd1,
        REQ_CLEAR    = 3'd2,
        REQ_COUNT    = 3'd3,
        REQ_CONTAINS = 3'd4,
        REQ_MAX      = 3'd5,
        REQ_MIN      = 3'd6
    } t_req_code;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // What one storage cell loads this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_PREV,
        CELL_LOAD_NEXT,
        CELL_LOAD_WRAP
    } t_cell_op;

    // Control to the search accumulator
    typedef struct packed {
        logic      start;
        logic      step;
        t_req_code req;
    } t_srch_ctl;

    // Request payload
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_value;
    } t_req;

    // Response payload
    typedef struct packed {
        logic               success;
        logic signed [31:0] answer;
        logic signed [31:0] top_value;
        logic [6:0]         entry_count;
        logic               is_empty;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/lss_cell.sv =====
// One stack cell: holds one entry and loads from a neighbor or the wrap bus.
`default_nettype none

module lss_cell (
    input  wire logic               i_clk,
    input  wire lss_pkg::t_cell_op  i_op,
    input  wire logic signed [31:0] i_prev,
    input  wire logic signed [31:0] i_next,
    input  wire logic signed [31:0] i_wrap,
    output logic signed [31:0]      o_value
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    // Source select
    always_comb begin
        case (i_op)
            lss_pkg::CELL_HOLD:      n_value = r_value;
            lss_pkg::CELL_LOAD_PREV: n_value = i_prev;
            lss_pkg::CELL_LOAD_NEXT: n_value = i_next;
            lss_pkg::CELL_LOAD_WRAP: n_value = i_wrap;
            default:                 n_value = r_value;
        endcase
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== hw/rtl/lss_search.sv =====
// Search accumulator: count, contains, maximum and minimum over streamed entries.
`default_nettype none

module lss_search (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lss_pkg::t_srch_ctl i_ctl,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_elem,
    output logic signed [31:0]      o_acc
);

    lss_pkg::t_req_code r_req;
    logic signed [31:0] r_key;
    logic signed [31:0] r_acc;
    logic               r_first;

    lss_pkg::t_req_code n_req;
    logic signed [31:0] n_key;
    logic signed [31:0] n_acc;
    logic               n_first;
    logic               w_eq;

    assign w_eq = (i_elem == r_key);

    // Accumulate one entry per step
    always_comb begin
        n_req   = r_req;
        n_key   = r_key;
        n_acc   = r_acc;
        n_first = r_first;
        if (i_ctl.start) begin
            n_req   = i_ctl.req;
            n_key   = i_key;
            n_acc   = '0;
            n_first = 1'b1;
        end else if (i_ctl.step) begin
            n_first = 1'b0;
            case (r_req)
                lss_pkg::REQ_COUNT:    n_acc = r_acc + 32'(w_eq);
                lss_pkg::REQ_CONTAINS: n_acc = r_acc | 32'(w_eq);
                lss_pkg::REQ_MAX:      if (r_first || (i_elem > r_acc)) n_acc = i_elem;
                lss_pkg::REQ_MIN:      if (r_first || (i_elem < r_acc)) n_acc = i_elem;
                default:               n_acc = r_acc;
            endcase
        end
    end

    // Control flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b0;
        end else begin
            r_first <= n_first;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_key <= n_key;
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== hw/rtl/lifo_stack_with_search.sv =====
// Top level: LIFO stack built as a row of shifting cells, with search.
// Push, pop, clear: response valid the cycle after the request is taken, one per
// cycle unless the response is held. Count, contains, max, min: stored cells rotate
// one entry a cycle into the search accumulator; the response is built once every
// entry has passed (at once if empty); no new request is taken until it is built.
// Reset clears the entry count and control; the cells themselves are not cleared.
`default_nettype none

module lifo_stack_with_search #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire lss_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output lss_pkg::t_rsp      o_rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    lss_pkg::t_state    r_state;
    lss_pkg::t_state    n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_left;
    logic [CW-1:0]      n_left;
    logic               r_out_valid;
    logic               n_out_valid;
    lss_pkg::t_rsp      r_rsp;

    logic               w_accept;
    logic               w_out_free;
    logic               w_push;
    logic               w_pop;
    logic               w_rotate;
    logic               w_cap;
    logic               w_ok;
    logic signed [31:0] w_ans;
    logic signed [31:0] w_top;
    logic signed [31:0] w_acc;
    lss_pkg::t_srch_ctl w_srch_ctl;
    lss_pkg::t_req_code w_code;

    logic signed [31:0] w_cell [0:STACK_DEPTH];
    lss_pkg::t_cell_op  w_op [0:STACK_DEPTH-1];

    assign w_code      = lss_pkg::t_req_code'(i_req.req_type);
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == lss_pkg::ST_IDLE) && w_out_free;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_cell[STACK_DEPTH] = '0;

    // Cell row; cell 0 is the top of the stack
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic signed [31:0] w_prev;

        if (g == 0) begin : g_head
            assign w_prev = i_req.operand_value;
        end else begin : g_body
            assign w_prev = w_cell[g-1];
        end

        // Per-cell load select; the last stored cell closes the ring while scanning
        always_comb begin
            w_op[g] = lss_pkg::CELL_HOLD;
            if (w_push) begin
                w_op[g] = lss_pkg::CELL_LOAD_PREV;
            end else if (w_pop) begin
                w_op[g] = lss_pkg::CELL_LOAD_NEXT;
            end else if (w_rotate) begin
                if (CW'(g + 1) == r_count) begin
                    w_op[g] = lss_pkg::CELL_LOAD_WRAP;
                end else if (CW'(g + 1) < r_count) begin
                    w_op[g] = lss_pkg::CELL_LOAD_NEXT;
                end
            end
        end

        lss_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_prev  (w_prev),
            .i_next  (w_cell[g+1]),
            .i_wrap  (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    lss_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_srch_ctl),
        .i_key   (i_req.operand_value),
        .i_elem  (w_cell[0]),
        .o_acc   (w_acc)
    );

    // Request decode, scan sequencing and response build
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_left         = r_left;
        w_push         = 1'b0;
        w_pop          = 1'b0;
        w_rotate       = 1'b0;
        w_cap          = 1'b0;
        w_ok           = 1'b0;
        w_ans          = '0;
        w_top          = (r_count != '0) ? w_cell[0] : '0;
        w_srch_ctl     = '{start: 1'b0, step: 1'b0, req: w_code};
        case (r_state)
            lss_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_code)
                        lss_pkg::REQ_PUSH: begin
                            w_cap = 1'b1;
                            if (r_count < CW'(STACK_DEPTH)) begin
                                w_push  = 1'b1;
                                w_ok    = 1'b1;
                                n_count = r_count + 1'b1;
                                w_top   = i_req.operand_value;
                            end
                        end
                        lss_pkg::REQ_POP: begin
                            w_cap = 1'b1;
                            if (r_count != '0) begin
                                w_pop   = 1'b1;
                                w_ok    = 1'b1;
                                n_count = r_count - 1'b1;
                                w_top   = (r_count == CW'(1)) ? '0 : w_cell[1];
                            end
                        end
                        lss_pkg::REQ_CLEAR: begin
                            w_cap   = 1'b1;
                            w_ok    = 1'b1;
                            n_count = '0;
                            w_top   = '0;
                        end
                        lss_pkg::REQ_COUNT, lss_pkg::REQ_CONTAINS: begin
                            if (r_count == '0) begin
                                w_cap = 1'b1;
                                w_ok  = 1'b1;
                            end else begin
                                w_srch_ctl.start = 1'b1;
                                n_left           = r_count;
                                n_state          = lss_pkg::ST_SCAN;
                            end
                        end
                        lss_pkg::REQ_MAX, lss_pkg::REQ_MIN: begin
                            if (r_count == '0) begin
                                w_cap = 1'b1;
                            end else begin
                                w_srch_ctl.start = 1'b1;
                                n_left           = r_count;
                                n_state          = lss_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            w_cap = 1'b1;
                        end
                    endcase
                end
            end
            lss_pkg::ST_SCAN: begin
                w_srch_ctl.step = 1'b1;
                w_rotate        = 1'b1;
                n_left          = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = lss_pkg::ST_DONE;
                end
            end
            lss_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_cap   = 1'b1;
                    w_ok    = 1'b1;
                    w_ans   = w_acc;
                    n_state = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cap) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lss_pkg::ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_rsp.success     <= w_ok;
            r_rsp.answer      <= w_ans;
            r_rsp.top_value   <= w_top;
            r_rsp.entry_count <= 7'(n_count);
            r_rsp.is_empty    <= (n_count == '0);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

`include "lifo_stack_with_search_assert.svh"

    // Entry count stays within the cell row
    `LSS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    // No new request while a scan is in flight
    `LSS_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, r_state != lss_pkg::ST_IDLE, !o_req_ready)
    // Last scan step hands over to the response state
    `LSS_ASSERT_NXT(a_scan_end, i_clk, i_rst_n,
        (r_state == lss_pkg::ST_SCAN) && (r_left == CW'(1)), r_state == lss_pkg::ST_DONE)
    // A successful push grows the count by one
    `LSS_ASSERT_NXT(a_push_grow, i_clk, i_rst_n, w_push, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire
